// ===== sv/direction_to_pitch_yaw_assert.svh =====
// assertion macros used by the top rtl file
`ifndef DIRECTION_TO_PITCH_YAW_ASSERT_SVH
`define DIRECTION_TO_PITCH_YAW_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define DTPY_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent after the delay given by dly
`define DTPY_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");

`else

`define DTPY_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DTPY_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons)

`endif

`endif

// ===== sv/dtpy_pkg.sv =====
`default_nettype none
package dtpy_pkg;

    // width of one angle field
    localparam int ANGLE_W = 25;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } dtpy_in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pitch_deg;
        logic [ANGLE_W-1:0] yaw_deg;
    } dtpy_out_t;

    // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
    function automatic logic [30:0] atan_deg(input int idx);
        logic [30:0] r;
        case (idx)
            0:  r = 31'd754974720;
            1:  r = 31'd445687602;
            2:  r = 31'd235489088;
            3:  r = 31'd119537938;
            4:  r = 31'd60000934;
            5:  r = 31'd30029717;
            6:  r = 31'd15018523;
            7:  r = 31'd7509720;
            8:  r = 31'd3754917;
            9:  r = 31'd1877466;
            10: r = 31'd938734;
            11: r = 31'd469367;
            12: r = 31'd234684;
            13: r = 31'd117342;
            14: r = 31'd58671;
            15: r = 31'd29335;
            16: r = 31'd14668;
            17: r = 31'd7334;
            18: r = 31'd3667;
            19: r = 31'd1833;
            20: r = 31'd917;
            21: r = 31'd458;
            22: r = 31'd229;
            23: r = 31'd115;
            24: r = 31'd57;
            25: r = 31'd29;
            26: r = 31'd14;
            27: r = 31'd7;
            28: r = 31'd4;
            29: r = 31'd2;
            30: r = 31'd1;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/dtpy_cordic_stage.sv =====
`default_nettype none
module dtpy_cordic_stage
    import dtpy_pkg::*;
#(
    parameter int SHIFT = 0,
    parameter int DW = 52,
    parameter int AW = 36,
    parameter int SW = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [DW-1:0] in_x,
    input  wire logic signed [DW-1:0] in_y,
    input  wire logic signed [AW-1:0] in_ang,
    input  wire logic [SW-1:0]        in_side,
    output logic                      out_valid,
    output logic signed [DW-1:0]      out_x,
    output logic signed [DW-1:0]      out_y,
    output logic signed [AW-1:0]      out_ang,
    output logic [SW-1:0]             out_side
);

    localparam logic signed [AW-1:0] ATAN_STEP = AW'(atan_deg(SHIFT));

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic [SW-1:0]        side_reg;
    logic signed [DW-1:0] dx, dy;

    // one micro-rotation toward the x axis
    always_comb
    begin
        dx = in_y >>> SHIFT;
        dy = in_x >>> SHIFT;
        if (in_y[DW-1])
        begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            ang_next = in_ang - ATAN_STEP;
        end
        else
        begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            ang_next = in_ang + ATAN_STEP;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== sv/direction_to_pitch_yaw.sv =====
// direction to pitch/yaw converter
// an item is a signed Q16.16 direction (dir); it is taken at a clock edge
// where start is high and busy is low. busy is always low: the pipeline
// takes one item every cycle.
// the result (pitch_deg, yaw_deg, unsigned degrees with FRAC_BITS fraction
// bits, in [0,360)) shows on result for exactly one cycle with done high.
// from the accept edge an item passes through one input stage with the
// z gain multiply, CORDIC_STEPS yaw rotation stages, one stage that forms
// the gain-scaled -z, CORDIC_STEPS pitch rotation stages and one output
// stage that folds and rounds the angles.
// throughput is one item per cycle; items never wait on each other.
// reset clears the valid bits of every stage, so no done appears until an
// item has gone through. the receiver cannot stall: each result is there
// for one cycle only.
// a vector with zero x and y gives yaw 0 and pitch 270 for z above zero,
// 90 otherwise.
`default_nettype none
module direction_to_pitch_yaw
    import dtpy_pkg::*;
#(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire dtpy_in_t  dir,
    output logic           done,
    output dtpy_out_t      result
);

`include "direction_to_pitch_yaw_assert.svh"

    localparam int DW = 52;
    localparam int AW = 36;
    localparam int PW = 64;
    localparam int SIDE1_W = PW + 2;
    localparam int SIDE2_W = AW + 2;
    localparam int LAT = 2 * CORDIC_STEPS + 3;
    localparam int RND_SH = 24 - FRAC_BITS;
    localparam int RND_SH_M1 = (RND_SH > 0) ? RND_SH - 1 : 0;
    localparam logic signed [AW-1:0] FULL_TURN = AW'(360) <<< 24;
    localparam logic signed [AW-1:0] HALF_TURN = AW'(180) <<< 24;
    localparam logic [AW-1:0] FULL_OUT = AW'(360) << FRAC_BITS;
    localparam logic [AW-1:0] PITCH_UP = AW'(270) << FRAC_BITS;
    localparam logic [AW-1:0] PITCH_DOWN = AW'(90) << FRAC_BITS;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

    // fold into one turn and round to the output fraction
    function automatic logic [ANGLE_W-1:0] fold_round(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] t;
        logic [AW-1:0] u;
        t = a;
        if (t < 0)
            t = t + FULL_TURN;
        if (t >= FULL_TURN)
            t = t - FULL_TURN;
        if (t < 0)
            t = '0;
        u = unsigned'(t);
        if (RND_SH > 0)
            u = ((u >> RND_SH_M1) + AW'(1)) >> 1;
        if (u >= FULL_OUT)
            u = u - FULL_OUT;
        return u[ANGLE_W-1:0];
    endfunction

    // input stage: scale, move to right half plane, gain multiply on z
    logic                 v0_reg;
    logic signed [DW-1:0] x0_reg, y0_reg, x0_next, y0_next;
    logic signed [AW-1:0] yaw0_reg, yaw0_next;
    logic signed [PW-1:0] prod0_reg, prod0_next;
    logic                 zero0_reg, zpos0_reg;
    logic signed [DW-1:0] xs, ys;

    always_comb
    begin
        xs = {{(DW-48){dir.dir_x[31]}}, dir.dir_x, 16'b0};
        ys = {{(DW-48){dir.dir_y[31]}}, dir.dir_y, 16'b0};
        prod0_next = dir.dir_z * GAIN_Q30;
        if (dir.dir_x[31])
        begin
            x0_next   = -xs;
            y0_next   = -ys;
            yaw0_next = HALF_TURN;
        end
        else
        begin
            x0_next   = xs;
            y0_next   = ys;
            yaw0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        yaw0_reg  <= yaw0_next;
        prod0_reg <= prod0_next;
        zero0_reg <= (dir.dir_x == '0) && (dir.dir_y == '0);
        zpos0_reg <= !dir.dir_z[31] && (dir.dir_z != '0);
    end

    // yaw pass
    logic                 v1 [0:CORDIC_STEPS];
    logic signed [DW-1:0] x1 [0:CORDIC_STEPS];
    logic signed [DW-1:0] y1 [0:CORDIC_STEPS];
    logic signed [AW-1:0] a1 [0:CORDIC_STEPS];
    logic [SIDE1_W-1:0]   s1 [0:CORDIC_STEPS];

    assign v1[0] = v0_reg;
    assign x1[0] = x0_reg;
    assign y1[0] = y0_reg;
    assign a1[0] = yaw0_reg;
    assign s1[0] = {prod0_reg, zero0_reg, zpos0_reg};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_yaw
        dtpy_cordic_stage #(
            .SHIFT(i), .DW(DW), .AW(AW), .SW(SIDE1_W)
        ) u_stage (
            .clk(clk), .rst_n(rst_n),
            .in_valid(v1[i]), .in_x(x1[i]), .in_y(y1[i]),
            .in_ang(a1[i]), .in_side(s1[i]),
            .out_valid(v1[i+1]), .out_x(x1[i+1]), .out_y(y1[i+1]),
            .out_ang(a1[i+1]), .out_side(s1[i+1])
        );
    end

    // middle stage: gain-scaled -z against the xy length
    logic                 vm_reg;
    logic signed [DW-1:0] rm_reg, nzm_reg;
    logic signed [AW-1:0] yawm_reg;
    logic                 zerom_reg, zposm_reg;
    logic signed [PW-1:0] prod_end, prod_sh;

    assign prod_end = signed'(s1[CORDIC_STEPS][SIDE1_W-1:2]);
    assign prod_sh  = prod_end >>> 14;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= v1[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        rm_reg    <= x1[CORDIC_STEPS];
        nzm_reg   <= -prod_sh[DW-1:0];
        yawm_reg  <= a1[CORDIC_STEPS];
        zerom_reg <= s1[CORDIC_STEPS][1];
        zposm_reg <= s1[CORDIC_STEPS][0];
    end

    // pitch pass
    logic                 v2 [0:CORDIC_STEPS];
    logic signed [DW-1:0] x2 [0:CORDIC_STEPS];
    logic signed [DW-1:0] y2 [0:CORDIC_STEPS];
    logic signed [AW-1:0] a2 [0:CORDIC_STEPS];
    logic [SIDE2_W-1:0]   s2 [0:CORDIC_STEPS];

    assign v2[0] = vm_reg;
    assign x2[0] = rm_reg;
    assign y2[0] = nzm_reg;
    assign a2[0] = '0;
    assign s2[0] = {yawm_reg, zerom_reg, zposm_reg};

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_pitch
        dtpy_cordic_stage #(
            .SHIFT(j), .DW(DW), .AW(AW), .SW(SIDE2_W)
        ) u_stage (
            .clk(clk), .rst_n(rst_n),
            .in_valid(v2[j]), .in_x(x2[j]), .in_y(y2[j]),
            .in_ang(a2[j]), .in_side(s2[j]),
            .out_valid(v2[j+1]), .out_x(x2[j+1]), .out_y(y2[j+1]),
            .out_ang(a2[j+1]), .out_side(s2[j+1])
        );
    end

    // output stage: fold, round, zero-xy override
    logic                 done_reg;
    dtpy_out_t            result_reg, result_next;
    logic signed [AW-1:0] yaw_end;
    logic                 zero_end, zpos_end;

    assign yaw_end  = signed'(s2[CORDIC_STEPS][SIDE2_W-1:2]);
    assign zero_end = s2[CORDIC_STEPS][1];
    assign zpos_end = s2[CORDIC_STEPS][0];

    always_comb
    begin
        if (zero_end)
        begin
            result_next.pitch_deg = zpos_end ? PITCH_UP[ANGLE_W-1:0]
                                             : PITCH_DOWN[ANGLE_W-1:0];
            result_next.yaw_deg   = '0;
        end
        else
        begin
            result_next.pitch_deg = fold_round(a2[CORDIC_STEPS]);
            result_next.yaw_deg   = fold_round(yaw_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v2[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `DTPY_ASSERT_DELAY(a_item_comes_out, clk, rst_n, start, LAT, done)
    `DTPY_ASSERT_IMPL(a_no_spurious_done, clk, rst_n, done, $past(start, LAT))
    `DTPY_ASSERT_IMPL(a_angles_in_turn, clk, rst_n, done, (AW'(result.pitch_deg) < FULL_OUT) && (AW'(result.yaw_deg) < FULL_OUT))
    `DTPY_ASSERT_DELAY(a_zero_xy_yaw, clk, rst_n, start && (dir.dir_x == '0) && (dir.dir_y == '0), LAT, result.yaw_deg == '0)

endmodule
`default_nettype wire
